/* design/cpd_pkg.sv */
package cpd_pkg;

  // Sizing
  localparam int MAX_OBJECTIVES = 16;
  localparam int VAL_W          = 32;
  localparam int NUM_W          = 5;
  localparam int EPS_W          = 31;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 32;
  localparam int VERDICT_W      = 2;
  localparam int CNT_W          = $clog2(MAX_OBJECTIVES + 1);
  localparam int POS_W          = (MAX_OBJECTIVES > 1) ? $clog2(MAX_OBJECTIVES) : 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_OBJECTIVES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON        = 4'd1;

  // Register reset values
  localparam logic [NUM_W-1:0] NUM_OBJECTIVES_RESET = 5'd2;
  localparam logic [EPS_W-1:0] EPSILON_RESET        = '0;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NONE   = 2'd0,
    VERDICT_FIRST  = 2'd1,
    VERDICT_SECOND = 2'd2
  } verdict_t;

  // One objective pair with both violation totals
  typedef struct packed {
    logic signed [VAL_W-1:0] obj_first;
    logic signed [VAL_W-1:0] obj_second;
    logic signed [VAL_W-1:0] viol_first;
    logic signed [VAL_W-1:0] viol_second;
  } item_t;

  // Decoded configuration seen by the evaluator
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             single;
    logic [EPS_W-1:0] eps;
  } cfg_t;

endpackage

/* design/cpd_item_if.sv */
interface cpd_item_if;
  logic                                valid;
  logic                                ready;
  logic signed [cpd_pkg::VAL_W-1:0]    obj_first;
  logic signed [cpd_pkg::VAL_W-1:0]    obj_second;
  logic signed [cpd_pkg::VAL_W-1:0]    viol_first;
  logic signed [cpd_pkg::VAL_W-1:0]    viol_second;

  modport source (
    output valid, obj_first, obj_second, viol_first, viol_second,
    input  ready
  );
  modport sink (
    input  valid, obj_first, obj_second, viol_first, viol_second,
    output ready
  );
endinterface

/* design/cpd_result_if.sv */
interface cpd_result_if;
  logic                            valid;
  logic                            ready;
  logic [cpd_pkg::VERDICT_W-1:0]   verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

/* design/cpd_cfg_if.sv */
interface cpd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cpd_pkg::CFG_IDX_W-1:0]    index;
  logic [cpd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/cpd_cfg_regs.sv */
module cpd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_valid,
  output logic                              wr_ready,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [cpd_pkg::CFG_DATA_W-1:0]    wr_data,
  output cpd_pkg::cfg_t                     cfg
);

  logic [cpd_pkg::NUM_W-1:0] num_objectives;
  logic [cpd_pkg::EPS_W-1:0] epsilon;
  logic [cpd_pkg::CNT_W-1:0] count;

  assign wr_ready = 1'b1;

  // Take register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      num_objectives <= cpd_pkg::NUM_OBJECTIVES_RESET;
      epsilon        <= cpd_pkg::EPSILON_RESET;
    end else if (wr_valid && wr_ready) begin
      case (wr_index)
        cpd_pkg::REG_NUM_OBJECTIVES: num_objectives <= wr_data[cpd_pkg::NUM_W-1:0];
        cpd_pkg::REG_EPSILON:        epsilon        <= wr_data[cpd_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the objective count into 1..MAX_OBJECTIVES
  always_comb begin
    if (num_objectives == '0) begin
      count = cpd_pkg::CNT_W'(1);
    end else if (32'(num_objectives) > cpd_pkg::MAX_OBJECTIVES) begin
      count = cpd_pkg::CNT_W'(cpd_pkg::MAX_OBJECTIVES);
    end else begin
      count = cpd_pkg::CNT_W'(num_objectives);
    end
  end

  assign cfg.count  = count;
  assign cfg.single = (count == cpd_pkg::CNT_W'(1));
  assign cfg.eps    = epsilon;

endmodule

/* design/cpd_in_stage.sv */
module cpd_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cpd_pkg::item_t  in_item,
  input  logic            advance,
  output logic            s1_valid,
  output cpd_pkg::item_t  s1_item
);

  // Room when empty or when the held item moves on this cycle
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

endmodule

/* design/cpd_eval.sv */
module cpd_eval (
  input  logic                             clk,
  input  logic                             rst,
  input  cpd_pkg::cfg_t                    cfg,
  input  logic                             s1_valid,
  input  cpd_pkg::item_t                   s1_item,
  output logic                             advance,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [cpd_pkg::VERDICT_W-1:0]    res_verdict
);

  localparam int SUM_W  = cpd_pkg::CNT_W + 1;
  localparam int DIFF_W = cpd_pkg::VAL_W + 1;

  logic [cpd_pkg::POS_W-1:0]          position;
  logic                               first_better_seen;
  logic                               second_better_seen;

  logic signed [cpd_pkg::VAL_W-1:0]   a;
  logic signed [cpd_pkg::VAL_W-1:0]   b;
  logic signed [cpd_pkg::VAL_W-1:0]   va;
  logic signed [cpd_pkg::VAL_W-1:0]   vb;
  logic signed [DIFF_W-1:0]           diff;
  logic [DIFF_W-1:0]                  mag;
  logic                               a_less;
  logic                               a_more;
  logic                               first_hit;
  logic                               second_hit;
  logic                               first_better_next;
  logic                               second_better_next;
  logic                               last;
  logic                               out_free;
  cpd_pkg::verdict_t                  verdict;

  assign a  = s1_item.obj_first;
  assign b  = s1_item.obj_second;
  assign va = s1_item.viol_first;
  assign vb = s1_item.viol_second;

  // Compare the objective pair; single-objective mode applies the tolerance
  always_comb begin
    a_less = (a < b);
    a_more = (a > b);
    diff   = DIFF_W'(a) - DIFF_W'(b);
    mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    if (cfg.single) begin
      first_hit  = (mag > DIFF_W'(cfg.eps)) && a_less;
      second_hit = (mag > DIFF_W'(cfg.eps)) && !a_less;
    end else begin
      first_hit  = a_less;
      second_hit = a_more;
    end
    first_better_next  = first_better_seen || first_hit;
    second_better_next = second_better_seen || second_hit;
  end

  assign last = (SUM_W'(position) + SUM_W'(1)) >= SUM_W'(cfg.count);

  // Rank by violation first, then by the objective flags
  always_comb begin
    if (va[cpd_pkg::VAL_W-1] && vb[cpd_pkg::VAL_W-1]) begin
      if (va > vb) begin
        verdict = cpd_pkg::VERDICT_FIRST;
      end else if (va < vb) begin
        verdict = cpd_pkg::VERDICT_SECOND;
      end else begin
        verdict = cpd_pkg::VERDICT_NONE;
      end
    end else if (va[cpd_pkg::VAL_W-1]) begin
      verdict = cpd_pkg::VERDICT_SECOND;
    end else if (vb[cpd_pkg::VAL_W-1]) begin
      verdict = cpd_pkg::VERDICT_FIRST;
    end else if (first_better_next && !second_better_next) begin
      verdict = cpd_pkg::VERDICT_FIRST;
    end else if (!first_better_next && second_better_next) begin
      verdict = cpd_pkg::VERDICT_SECOND;
    end else begin
      verdict = cpd_pkg::VERDICT_NONE;
    end
  end

  // A last item waits only while the result register is full and stalled
  assign out_free = !res_valid || res_ready;
  assign advance  = s1_valid && (!last || out_free);

  // Advance the position and flags; clear them after a verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      position           <= '0;
      first_better_seen  <= 1'b0;
      second_better_seen <= 1'b0;
    end else if (advance) begin
      if (last) begin
        position           <= '0;
        first_better_seen  <= 1'b0;
        second_better_seen <= 1'b0;
      end else begin
        position           <= position + cpd_pkg::POS_W'(1);
        first_better_seen  <= first_better_next;
        second_better_seen <= second_better_next;
      end
    end
  end

  // Hold the verdict until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last) begin
      res_verdict <= verdict;
    end
  end

  a_clear_after_verdict: assert property (@(posedge clk) disable iff (rst)
    advance && last |=> position == '0 && !first_better_seen && !second_better_seen)
    else $error("comparison state not cleared after verdict");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_valid && last && res_valid && !res_ready |-> !advance)
    else $error("verdict would overwrite a stalled result");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_verdict))
    else $error("stalled verdict changed or dropped");

  a_flags_from_item: assert property (@(posedge clk) disable iff (rst)
    advance && !last && first_hit |=> first_better_seen)
    else $error("first-better flag lost on a non-final item");

endmodule

/* design/constrained_pareto_dominance.sv */
// Constrained Pareto dominance comparator, one objective pair per item.
// Items wait in the input stage register; each verdict is registered in the result register.
// Throughput: one item per cycle but for the stall below; one compare plus flag update sets it.
// A final item stalls only while the previous verdict waits in the result register.
// Reset (rst, synchronous): clears position, flags and valids; num_objectives = 2, epsilon = 0.
module constrained_pareto_dominance (
  input  logic          clk,
  input  logic          rst,
  cpd_item_if.sink      item,
  cpd_result_if.source  result,
  cpd_cfg_if.sink       cfg
);

  cpd_pkg::cfg_t   cfg_dec;
  cpd_pkg::item_t  in_item;
  cpd_pkg::item_t  s1_item;
  logic            s1_valid;
  logic            advance;

  assign in_item.obj_first   = item.obj_first;
  assign in_item.obj_second  = item.obj_second;
  assign in_item.viol_first  = item.viol_first;
  assign in_item.viol_second = item.viol_second;

  cpd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_dec)
  );

  cpd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  cpd_eval u_eval (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_dec),
    .s1_valid    (s1_valid),
    .s1_item     (s1_item),
    .advance     (advance),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_verdict (result.verdict)
  );

endmodule

/* verif/constrained_pareto_dominance_tb.sv */
`timescale 1ns / 1ps

module constrained_pareto_dominance_tb;
  import cpd_pkg::*;

  localparam int ITEM_TARGET     = 1500;
  localparam int DRAIN_CYCLES    = 4;    // verdict latency plus margin
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_PCT        = 37;
  localparam int CALM_PHASE      = 3;
  localparam int PRESSURE_PHASE  = 6;

  // Index outside the register map, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd9;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] ONE     = 32'sh0001_0000;  // 1.0 in Q16.16
  localparam logic signed [VAL_W-1:0] ZERO    = 32'sh0;
  localparam logic [EPS_W-1:0]        EPS_MAX = '1;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {TREND_FIRST, TREND_SECOND, TREND_EQUAL, TREND_MIXED} trend_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic signed [VAL_W-1:0] va;
    logic signed [VAL_W-1:0] vb;
    logic                    typed;
    verdict_t                verdict;
  } stim_row_t;

  // Directed stimulus; verdict typed in where it is obvious, else predicted
  localparam int DIRECTED_ROWS = 34;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // two objectives after reset, epsilon zero
    '{ROW_ITEM, REG_SPARE, '0, VAL_MIN, VAL_MAX, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, ZERO, ZERO, ZERO, ZERO, 1'b1, VERDICT_FIRST},
    '{ROW_ITEM, REG_SPARE, '0, VAL_MAX, VAL_MIN, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, ONE, ONE, ZERO, ZERO, 1'b1, VERDICT_SECOND},
    '{ROW_ITEM, REG_SPARE, '0, -32'sd3, 32'sd7, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, 32'sd7, -32'sd3, ZERO, ZERO, 1'b1, VERDICT_NONE},
    // infeasible first loses despite better objectives
    '{ROW_ITEM, REG_SPARE, '0, 32'sd1, 32'sd2, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, 32'sd1, 32'sd2, -32'sd1, ZERO, 1'b1, VERDICT_SECOND},
    '{ROW_ITEM, REG_SPARE, '0, 32'sd9, 32'sd2, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, 32'sd9, 32'sd2, ZERO, VAL_MIN, 1'b1, VERDICT_FIRST},
    // both infeasible, with equal then unequal violations
    '{ROW_ITEM, REG_SPARE, '0, 32'sd1, 32'sd2, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, 32'sd1, 32'sd2, -32'sd100, -32'sd100, 1'b1, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, ZERO, ZERO, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, ZERO, ZERO, VAL_MIN, -32'sd1, 1'b1, VERDICT_SECOND},
    // positive violation counts as feasible
    '{ROW_ITEM, REG_SPARE, '0, 32'sd4, 32'sd8, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, 32'sd8, 32'sd8, ONE, ZERO, 1'b0, VERDICT_NONE},
    // count zero falls back to epsilon mode; bit 31 of epsilon is dropped
    '{ROW_CFG, REG_EPSILON, 32'h8000_0000, ZERO, ZERO, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_CFG, REG_NUM_OBJECTIVES, 32'hFFFF_FFE0, ZERO, ZERO, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, 32'sd3, 32'sd3, ZERO, ZERO, 1'b1, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, VAL_MIN, VAL_MAX, ZERO, ZERO, 1'b1, VERDICT_FIRST},
    '{ROW_CFG, REG_EPSILON, 32'hFFFF_FFFF, ZERO, ZERO, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, VAL_MAX, ZERO, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, ZERO, VAL_MIN, ZERO, VAL_MAX, 1'b0, VERDICT_NONE},
    // unmapped index, then a count that saturates, shrunk mid-comparison
    '{ROW_CFG, REG_SPARE, 32'hFFFF_FFFF, ZERO, ZERO, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_CFG, REG_NUM_OBJECTIVES, 32'h0000_001F, ZERO, ZERO, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, 32'sd5, 32'sd6, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, 32'sd6, 32'sd5, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, VAL_MIN, VAL_MIN, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_CFG, REG_NUM_OBJECTIVES, 32'h0000_0002, ZERO, ZERO, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, ZERO, ZERO, -32'sd1, -32'sd2, 1'b0, VERDICT_NONE},
    // epsilon boundary: one above counts, equal does not
    '{ROW_CFG, REG_NUM_OBJECTIVES, 32'h0000_0001, ZERO, ZERO, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_CFG, REG_EPSILON, 32'h0000_0010, ZERO, ZERO, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, ZERO, 32'sd17, ZERO, ZERO, 1'b0, VERDICT_NONE},
    '{ROW_ITEM, REG_SPARE, '0, ZERO, -32'sd16, ZERO, ZERO, 1'b0, VERDICT_NONE}
  };

  logic clk;
  logic rst;

  cpd_item_if   item_bus ();
  cpd_result_if verdict_bus ();
  cpd_cfg_if    cfg_bus ();

  constrained_pareto_dominance i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (verdict_bus),
    .cfg    (cfg_bus)
  );

  // Predictor state and its copy of the registers
  logic [NUM_W-1:0] pm_count;
  logic [EPS_W-1:0] pm_eps;
  logic [3:0]       pm_pos;
  bit               pm_first_better;
  bit               pm_second_better;

  verdict_t pending_verdicts [$];
  int       mismatches;
  int       items_sent;
  int       holds_requested;
  bit       calm;
  trend_t   trend;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic int unsigned active_count();
    if (pm_count == 0) begin
      return 1;
    end
    if (pm_count > MAX_OBJECTIVES) begin
      return MAX_OBJECTIVES;
    end
    return 32'(pm_count);
  endfunction

  // Fold one objective pair into the dominance flags; give a verdict on the last one
  task automatic judge_pair(input item_t p, output bit done, output verdict_t v);
    int unsigned             n;
    logic signed [VAL_W:0]   diff;
    logic [VAL_W:0]          mag;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic signed [VAL_W-1:0] va;
    logic signed [VAL_W-1:0] vb;
    n = active_count();
    a = p.obj_first;
    b = p.obj_second;
    va = p.viol_first;
    vb = p.viol_second;
    done = 1'b0;
    v = VERDICT_NONE;
    if (n > 1) begin
      if (a < b) begin
        pm_first_better = 1'b1;
      end else if (a > b) begin
        pm_second_better = 1'b1;
      end
    end else begin
      diff = $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
      mag = diff[VAL_W] ? -diff : diff;
      if (mag > {2'b00, pm_eps}) begin
        if (a < b) begin
          pm_first_better = 1'b1;
        end else begin
          pm_second_better = 1'b1;
        end
      end
    end
    if (pm_pos + 1 < n) begin
      pm_pos = pm_pos + 1'b1;
    end else begin
      // a positive violation is feasible
      if (va > 0) begin
        va = '0;
      end
      if (vb > 0) begin
        vb = '0;
      end
      if (va < 0 && vb < 0) begin
        if (va > vb) begin
          v = VERDICT_FIRST;
        end else if (va < vb) begin
          v = VERDICT_SECOND;
        end
      end else if (va < 0) begin
        v = VERDICT_SECOND;
      end else if (vb < 0) begin
        v = VERDICT_FIRST;
      end else if (pm_first_better && !pm_second_better) begin
        v = VERDICT_FIRST;
      end else if (!pm_first_better && pm_second_better) begin
        v = VERDICT_SECOND;
      end
      done = 1'b1;
      pm_pos = '0;
      pm_first_better = 1'b0;
      pm_second_better = 1'b0;
    end
  endtask

  // Offer one item, idling at random first; leave valid high when accepted
  task automatic send_pair(input item_t p, input bit typed, input verdict_t typed_v);
    bit       done;
    verdict_t v;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid       <= 1'b1;
    item_bus.obj_first   <= p.obj_first;
    item_bus.obj_second  <= p.obj_second;
    item_bus.viol_first  <= p.viol_first;
    item_bus.viol_second <= p.viol_second;
    @(posedge clk);
    while (!item_bus.ready) begin
      @(posedge clk);
    end
    judge_pair(p, done, v);
    if (done) begin
      pending_verdicts.push_back(typed ? typed_v : v);
    end
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) begin
      @(posedge clk);
    end
    case (idx)
      REG_NUM_OBJECTIVES: pm_count = data[NUM_W-1:0];
      REG_EPSILON:        pm_eps = data[EPS_W-1:0];
      default: ;
    endcase
  endtask

  // Drop valid, wait for every verdict, then let the pipeline empty
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return ZERO;
      3:       return VAL_W'(int'($urandom_range(0, 511)) - 256);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_violation();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return ZERO;
    end else if (r < 68) begin
      return -32'sd1;
    end else if (r < 80) begin
      return {1'b1, 31'($urandom)};
    end else if (r < 88) begin
      return -VAL_W'($urandom_range(1, 1000));
    end else if (r < 95) begin
      return VAL_MIN;
    end
    return {1'b0, 31'($urandom)};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_count_word();
    logic [CFG_DATA_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0:       w[NUM_W-1:0] = '0;
      1:       w[NUM_W-1:0] = 5'd1;
      2:       w[NUM_W-1:0] = 5'd16;
      3:       w[NUM_W-1:0] = 5'd31;
      4:       w[NUM_W-1:0] = 5'($urandom_range(17, 30));
      5:       w[NUM_W-1:0] = 5'd2;
      default: w[NUM_W-1:0] = 5'($urandom_range(1, 6));
    endcase
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_eps_word();
    logic [EPS_W-1:0] e;
    case ($urandom_range(0, 3))
      0:       e = '0;
      1:       e = EPS_MAX;
      2:       e = EPS_W'($urandom_range(0, 300));
      default: e = EPS_W'($urandom);
    endcase
    return {1'($urandom_range(0, 1)), e};
  endfunction

  // Random pair; a comparison keeps one trend so dominance actually occurs
  task automatic draw_pair(output item_t p);
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] t;
    logic signed [VAL_W:0]   off;
    if (pm_pos == 0) begin
      trend = trend_t'($urandom_range(0, 3));
    end
    x = pick_value();
    y = pick_value();
    if (active_count() == 1) begin
      // land on either side of the epsilon boundary
      case ($urandom_range(0, 4))
        0:       off = $signed({2'b00, pm_eps});
        1:       off = $signed({2'b00, pm_eps}) + 1;
        2:       off = -$signed({2'b00, pm_eps});
        3:       off = -$signed({2'b00, pm_eps}) - 1;
        default: off = $signed({y[VAL_W-1], y});
      endcase
      y = x + off[VAL_W-1:0];
    end else begin
      case (trend)
        TREND_FIRST: begin
          if (x > y) begin
            t = x;
            x = y;
            y = t;
          end
        end
        TREND_SECOND: begin
          if (x < y) begin
            t = x;
            x = y;
            y = t;
          end
        end
        TREND_EQUAL: y = x;
        default: ;
      endcase
    end
    p.obj_first = x;
    p.obj_second = y;
    p.viol_first = pick_violation();
    p.viol_second = ($urandom_range(0, 9) == 0) ? p.viol_first : pick_violation();
  endtask

  // Result side: random stalls, a calm stretch and a long hold-off on request
  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left = 0;
    verdict_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served != holds_requested) begin
        holds_served++;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        verdict_bus.ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        verdict_bus.ready <= 1'b1;
      end else begin
        verdict_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Check each accepted verdict against the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && verdict_bus.valid && verdict_bus.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %0d with none expected", verdict_bus.verdict));
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict_bus.verdict !== want) begin
          report_mismatch($sformatf("verdict %0d, expected %0d", verdict_bus.verdict, want));
        end
      end
    end
  end

  // Stimulus: directed table, then random phases
  initial begin
    stim_row_t   row;
    item_t       p;
    int unsigned span;
    int          phase;
    rst                  <= 1'b1;
    item_bus.valid       <= 1'b0;
    item_bus.obj_first   <= '0;
    item_bus.obj_second  <= '0;
    item_bus.viol_first  <= '0;
    item_bus.viol_second <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= '0;
    cfg_bus.data         <= '0;
    pm_count = NUM_OBJECTIVES_RESET;
    pm_eps = EPSILON_RESET;
    pm_pos = '0;
    pm_first_better = 1'b0;
    pm_second_better = 1'b0;
    mismatches = 0;
    items_sent = 0;
    holds_requested = 0;
    calm = 1'b0;
    trend = TREND_MIXED;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.idx, row.data);
        cfg_bus.valid <= 1'b0;
      end else begin
        p.obj_first = row.a;
        p.obj_second = row.b;
        p.viol_first = row.va;
        p.viol_second = row.vb;
        send_pair(p, row.typed, row.verdict);
      end
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      write_reg(REG_NUM_OBJECTIVES, pick_count_word());
      write_reg(REG_EPSILON, pick_eps_word());
      span = $urandom_range(10, 90);
      calm = (phase == CALM_PHASE);
      if (calm) begin
        span = 200;
      end
      if (phase == PRESSURE_PHASE) begin
        // one verdict per item, receiver holds off, input must back up
        write_reg(REG_NUM_OBJECTIVES, 32'(1));
        holds_requested++;
        span = 80;
      end
      cfg_bus.valid <= 1'b0;
      repeat (span) begin
        draw_pair(p);
        send_pair(p, 1'b0, VERDICT_NONE);
      end
      phase++;
    end
    settle();
    calm = 1'b0;

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
design/cpd_pkg.sv
design/cpd_item_if.sv
design/cpd_result_if.sv
design/cpd_cfg_if.sv
design/cpd_cfg_regs.sv
design/cpd_in_stage.sv
design/cpd_eval.sv
design/constrained_pareto_dominance.sv
verif/constrained_pareto_dominance_tb.sv
